// ----- rtl/core/pbv_pkg.sv -----
// Shared types and constants of the polygon back-face visibility block.
// No dependencies; every other file imports this package.
package pbv_pkg;

  localparam int unsigned CoordW  = 37;   // camera-frame coordinate, scale 2^-28
  localparam int unsigned EdgeW   = 38;   // edge vector component
  localparam int unsigned NormW   = 77;   // face normal component, scale 2^-56
  localparam int unsigned DotW    = 116;  // normal dotted with vertex 0
  localparam int unsigned SqW     = 154;  // one squared normal component
  localparam int unsigned Norm2W  = 156;  // squared length of the normal
  localparam int unsigned ChunkW  = 24;   // operand slice of the split multiplier
  localparam int unsigned NumStg  = 11;   // pipeline depth
  localparam int unsigned AddrW   = 6;

  localparam logic [2:0] RegRow0   = 3'd0;
  localparam logic [2:0] RegRow1   = 3'd1;
  localparam logic [2:0] RegRow2   = 3'd2;
  localparam logic [2:0] RegTrans  = 3'd3;
  localparam logic [2:0] RegVisLim = 3'd4;
  localparam logic [2:0] RegAppLim = 3'd5;
  localparam logic [2:0] RegCosSq  = 3'd6;

  typedef struct packed {
    logic              func;
    logic [7:0]        corner_count;
    logic signed [15:0] v0_x;
    logic signed [15:0] v0_y;
    logic signed [15:0] v0_z;
    logic signed [15:0] v1_x;
    logic signed [15:0] v1_y;
    logic signed [15:0] v1_z;
    logic signed [15:0] v2_x;
    logic signed [15:0] v2_y;
    logic signed [15:0] v2_z;
  } in_t;

  typedef struct packed {
    logic visible;
    logic appearing;
  } out_t;

  typedef struct packed {
    logic [2:0][53:0] rot;
    logic [59:0]      trans;
    logic [31:0]      vis_lim;
    logic [31:0]      app_lim;
    logic [16:0]      cos_sq;
  } cfg_t;

endpackage

// ----- rtl/core/polygon_backface_visibility.sv -----
// Top level of the polygon back-face visibility pipeline.
// Depends on pbv_pkg, pbv_regs and pbv_mul.
//
//   port group      direction  handshake          payload
//   in_*            request in valid/ready        in_t  (mode, corners, 3 vertices)
//   out_*           result out valid/ready        out_t (visible, appearing)
//   psel..pready    config     APB setup/access   64-bit registers at 8*index
//
// An accepted request passes through stages 0 to 10 to its result; one request can
// enter every cycle while the output is not stalled, as the split multipliers of the
// cross-product, dot-product and norm stages are pipelined. Reset clears only the stage
// valid bits and loads the pose and limit registers. A stage takes new data whenever it
// is empty or its successor moves on, so a stalled output only backs up as far as needed.
module polygon_backface_visibility
  import pbv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  cfg_t cfg;

  pbv_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // Stage valid bits and the mode and small-polygon flags that ride along.
  logic [NumStg-1:0] v_q, ld, fn_q, sm_q;

  always_comb begin
    ld[NumStg-1] = !v_q[NumStg-1] || out_ready_i;
    for (int i = NumStg - 2; i >= 0; i--) begin
      ld[i] = !v_q[i] || ld[i+1];
    end
  end

  assign in_ready_o = ld[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < NumStg; i++) begin
        if (ld[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      fn_q[0] <= in_data_i.func;
      sm_q[0] <= (in_data_i.corner_count <= 8'd2);
    end
    for (int i = 1; i < NumStg; i++) begin
      if (ld[i]) begin
        fn_q[i] <= fn_q[i-1];
        sm_q[i] <= sm_q[i-1];
      end
    end
  end

  // Stage 0: rotate and translate the three vertices into the camera frame.
  logic signed [15:0]       vtx [3][3];
  logic signed [CoordW-1:0] cam [3][3];
  logic signed [CoordW-1:0] cam_q [3][3];
  logic signed [33:0]       rot_term;

  assign vtx[0] = '{in_data_i.v0_x, in_data_i.v0_y, in_data_i.v0_z};
  assign vtx[1] = '{in_data_i.v1_x, in_data_i.v1_y, in_data_i.v1_z};
  assign vtx[2] = '{in_data_i.v2_x, in_data_i.v2_y, in_data_i.v2_z};

  always_comb begin
    rot_term = '0;
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 3; r++) begin
        cam[k][r] = CoordW'($signed(cfg.trans[20*r +: 20])) <<< 16;
        for (int j = 0; j < 3; j++) begin
          rot_term  = $signed(cfg.rot[r][18*j +: 18]) * vtx[k][j];
          cam[k][r] = cam[k][r] + CoordW'(rot_term);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) cam_q <= cam;
  end

  // Stage 1: edge vectors; vertex 0 is carried on to the dot product.
  logic signed [EdgeW-1:0]  e1_q [3];
  logic signed [EdgeW-1:0]  e2_q [3];
  logic signed [CoordW-1:0] c0_q [1:4][3];

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      for (int r = 0; r < 3; r++) begin
        e1_q[r] <= EdgeW'(cam_q[1][r]) - EdgeW'(cam_q[0][r]);
        e2_q[r] <= EdgeW'(cam_q[2][r]) - EdgeW'(cam_q[1][r]);
      end
      c0_q[1] <= cam_q[0];
    end
    for (int s = 2; s <= 4; s++) begin
      if (ld[s]) c0_q[s] <= c0_q[s-1];
    end
  end

  // Stages 2 and 3: the six cross-product terms.
  logic signed [2*EdgeW-1:0] xp [6];
  logic signed [EdgeW-1:0]   xa [6];
  logic signed [EdgeW-1:0]   xb [6];

  assign xa = '{e1_q[1], e1_q[2], e1_q[2], e1_q[0], e1_q[0], e1_q[1]};
  assign xb = '{e2_q[2], e2_q[1], e2_q[0], e2_q[2], e2_q[1], e2_q[0]};

  for (genvar g = 0; g < 6; g++) begin : g_cross
    pbv_mul #(.AW(EdgeW), .BW(EdgeW)) u_mul (
      .clk_i, .en1_i(ld[2]), .en2_i(ld[3]), .a_i(xa[g]), .b_i(xb[g]), .p_o(xp[g])
    );
  end

  // Stage 4: normal components.
  logic signed [NormW-1:0] n_q [3];

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      n_q[0] <= NormW'(xp[0]) - NormW'(xp[1]);
      n_q[1] <= NormW'(xp[2]) - NormW'(xp[3]);
      n_q[2] <= NormW'(xp[4]) - NormW'(xp[5]);
    end
  end

  // Stages 5 and 6: dot-product terms and squared normal components.
  logic signed [CoordW+NormW-1:0] dp [3];
  logic signed [2*NormW-1:0]      sq [3];
  logic                           nzneg_q [5:9];

  for (genvar g = 0; g < 3; g++) begin : g_dot
    pbv_mul #(.AW(CoordW), .BW(NormW)) u_dot (
      .clk_i, .en1_i(ld[5]), .en2_i(ld[6]), .a_i(c0_q[4][g]), .b_i(n_q[g]), .p_o(dp[g])
    );
    pbv_mul #(.AW(NormW), .BW(NormW)) u_sq (
      .clk_i, .en1_i(ld[5]), .en2_i(ld[6]), .a_i(n_q[g]), .b_i(n_q[g]), .p_o(sq[g])
    );
  end

  // The sign of nz rides along until the angle test settles in stage 10.
  always_ff @(posedge clk_i) begin
    if (ld[5]) nzneg_q[5] <= n_q[2][NormW-1];
    for (int s = 6; s <= 9; s++) begin
      if (ld[s]) nzneg_q[s] <= nzneg_q[s-1];
    end
  end

  // Stage 7: sum the dot product and the norm, settle the plain-cull result.
  logic signed [DotW-1:0]   dot;
  logic signed [DotW:0]     vis_th, app_th;
  logic                     vis0_d, app0_d, dneg_d;
  logic [Norm2W-1:0]        norm2_q;
  logic [SqW+15:0]          lhs_q [7:9];
  logic [7:9]               vis0_q, app0_q, dneg_q;

  assign dot    = DotW'(dp[0]) + DotW'(dp[1]) + DotW'(dp[2]);
  assign vis_th = -$signed((DotW+1)'({cfg.vis_lim, 48'b0}));
  assign app_th = $signed((DotW+1)'({cfg.app_lim, 48'b0}));
  assign vis0_d = (DotW+1)'(dot) < vis_th;
  assign app0_d = (DotW+1)'(dot) < app_th;
  assign dneg_d = dot[DotW-1];

  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      norm2_q   <= Norm2W'(sq[0][SqW-1:0]) + Norm2W'(sq[1][SqW-1:0])
                 + Norm2W'(sq[2][SqW-1:0]);
      lhs_q[7]  <= {sq[2][SqW-1:0], 16'b0};
      vis0_q[7] <= vis0_d;
      app0_q[7] <= app0_d;
      dneg_q[7] <= dneg_d;
    end
    for (int s = 8; s <= 9; s++) begin
      if (ld[s]) begin
        lhs_q[s]   <= lhs_q[s-1];
        vis0_q[s]  <= vis0_q[s-1];
        app0_q[s]  <= app0_q[s-1];
        dneg_q[s]  <= dneg_q[s-1];
      end
    end
  end

  // Stages 8 and 9: cos_alpha_sq times the squared norm for the angle test.
  logic signed [Norm2W+17:0] rhs;

  pbv_mul #(.AW(Norm2W), .BW(18)) u_rhs (
    .clk_i, .en1_i(ld[8]), .en2_i(ld[9]),
    .a_i($signed(norm2_q)), .b_i($signed({1'b0, cfg.cos_sq})), .p_o(rhs)
  );

  // Stage 10: output register.
  logic vis1;
  out_t res_d, res_q;

  assign vis1 = dneg_q[9] && nzneg_q[9] && ($unsigned(rhs) < (Norm2W+18)'(lhs_q[9]));

  always_comb begin
    if (sm_q[9]) begin
      res_d = '{visible: 1'b1, appearing: 1'b0};
    end else if (fn_q[9]) begin
      res_d = '{visible: vis1, appearing: 1'b0};
    end else begin
      res_d = '{visible: vis0_q[9], appearing: !vis0_q[9] && app0_q[9]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[10]) res_q <= res_d;
  end

  assign out_valid_o = v_q[NumStg-1];
  assign out_data_o  = res_q;

  // A result is never both visible and appearing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.visible && out_data_o.appearing))
    else $error("visible and appearing both set");

  // The angle-limited mode never reports appearing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fn_q[NumStg-1] |-> !out_data_o.appearing)
    else $error("appearing reported in angle mode");

  // Polygons with two or fewer corners come out visible.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sm_q[NumStg-1] |-> out_data_o.visible)
    else $error("small polygon not visible");

  // An accepted request occupies the first stage in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted request lost at entry");

endmodule

// ----- rtl/core/pbv_mul.sv -----
// Two-stage signed multiplier split into slice products of at most 25x25 bits.
// Depends on pbv_pkg for the slice width.
module pbv_mul
  import pbv_pkg::*;
#(
  parameter int unsigned AW = 38,
  parameter int unsigned BW = 38
) (
  input  logic                     clk_i,
  input  logic                     en1_i,
  input  logic                     en2_i,
  input  logic signed [AW-1:0]     a_i,
  input  logic signed [BW-1:0]     b_i,
  output logic signed [AW+BW-1:0]  p_o
);

  localparam int unsigned NA = (AW + ChunkW - 1) / ChunkW;
  localparam int unsigned NB = (BW + ChunkW - 1) / ChunkW;
  localparam int unsigned PW = AW + BW;
  localparam int unsigned SW = 2 * ChunkW + 2;

  logic signed [NA*ChunkW-1:0] a_ext;
  logic signed [NB*ChunkW-1:0] b_ext;
  logic signed [ChunkW:0]      a_sl [NA];
  logic signed [ChunkW:0]      b_sl [NB];
  logic signed [SW-1:0]        pp_q [NA][NB];
  logic signed [PW-1:0]        sum;
  logic signed [PW-1:0]        p_q;

  assign a_ext = (NA*ChunkW)'(a_i);
  assign b_ext = (NB*ChunkW)'(b_i);

  // Lower slices are unsigned, the top slice carries the sign.
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) a_sl[i] = {a_ext[NA*ChunkW-1], a_ext[i*ChunkW +: ChunkW]};
      else             a_sl[i] = {1'b0, a_ext[i*ChunkW +: ChunkW]};
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) b_sl[j] = {b_ext[NB*ChunkW-1], b_ext[j*ChunkW +: ChunkW]};
      else             b_sl[j] = {1'b0, b_ext[j*ChunkW +: ChunkW]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= a_sl[i] * b_sl[j];
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (PW'(pp_q[i][j]) <<< ((i + j) * ChunkW));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      p_q <= sum;
    end
  end

  assign p_o = p_q;

endmodule

// ----- rtl/core/pbv_regs.sv -----
// Configuration register file with an APB-style access port.
// Depends on pbv_pkg for the register codes and the configuration struct.
module pbv_regs
  import pbv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q;
  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot[0]  <= 54'd65536;
      cfg_q.rot[1]  <= 54'd65536 << 18;
      cfg_q.rot[2]  <= 54'd65536 << 36;
      cfg_q.trans   <= '0;
      cfg_q.vis_lim <= 32'd687195;
      cfg_q.app_lim <= 32'd6872;
      cfg_q.cos_sq  <= '0;
    end else if (wr) begin
      unique case (idx)
        RegRow0:   cfg_q.rot[0]  <= pwdata[53:0];
        RegRow1:   cfg_q.rot[1]  <= pwdata[53:0];
        RegRow2:   cfg_q.rot[2]  <= pwdata[53:0];
        RegTrans:  cfg_q.trans   <= pwdata[59:0];
        RegVisLim: cfg_q.vis_lim <= pwdata[31:0];
        RegAppLim: cfg_q.app_lim <= pwdata[31:0];
        RegCosSq:  cfg_q.cos_sq  <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegRow0:   prdata = 64'(cfg_q.rot[0]);
      RegRow1:   prdata = 64'(cfg_q.rot[1]);
      RegRow2:   prdata = 64'(cfg_q.rot[2]);
      RegTrans:  prdata = 64'(cfg_q.trans);
      RegVisLim: prdata = 64'(cfg_q.vis_lim);
      RegAppLim: prdata = 64'(cfg_q.app_lim);
      RegCosSq:  prdata = 64'(cfg_q.cos_sq);
      default:   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
